// ===== rtl/core/qmh_pkg.sv =====
// Package for the quaternary min-heap: status codes and the sequencer state type.
// No dependencies.
package qmh_pkg;
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_EX_RD,
		S_EX_ROOT,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} state_t;
endpackage

// ===== rtl/core/qmh_ram.sv =====
// Generic single-port RAM with a registered read.
// No dependencies.
module qmh_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/core/quaternary_min_heap.sv =====
// Top level of the 4-ary min-heap priority queue.
// Depends on qmh_pkg and qmh_ram.
//
// An item is an insert (op 0) or an extract of the minimum (op 1). The heap
// lives in one single-port RAM with a registered read; the sequencer walks it
// one RAM access per cycle. An insert compares the new entry with each parent
// in turn and moves larger parents down; an extract reads the root as the
// result, moves the last entry to the root and sifts it down, reading up to
// four children per level and writing back the smallest. A full insert or an
// empty extract goes straight to the result. Time is set by the single RAM
// port. One item is worked at a time; the result sits in an output register,
// and the next item is taken in the cycle after the result is handed off.
module quaternary_min_heap #(
	parameter int CAPACITY = 256,
	parameter int KEY_BITS = 32,
	parameter int TAG_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic [KEY_BITS-1:0] key,
	input  logic [TAG_BITS-1:0] tag,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         out_key,
	output logic [15:0]         out_tag,
	output logic [1:0]          status,
	output logic [8:0]          count
);
	import qmh_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = KEY_BITS + TAG_BITS;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] pos_q;      // position of the moving entry
	logic [AW-1:0] par_q;      // parent under test (sift-up)
	logic [EW-1:0] ent_q;      // moving entry
	logic [CW-1:0] lim_q;      // count after removal
	logic [2:0]    ci_q;       // child index being read
	logic [EW-1:0] best_q;
	logic [AW-1:0] best_pos_q;
	logic          have_best_q;
	logic [CW+1:0] first_q;    // first child, wide enough for overflow

	logic          we;
	logic [AW-1:0] addr;
	logic [EW-1:0] wdata, rdata;

	qmh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	function automatic logic [KEY_BITS-1:0] k_of(input logic [EW-1:0] e);
		return e[EW-1:TAG_BITS];
	endfunction

	logic [CW+1:0] child_c;
	assign child_c = first_q + (CW+2)'(ci_q);
	logic [CW+1:0] next_first;
	assign next_first = (CW+2)'({best_pos_q, 2'b00}) + (CW+2)'(1);

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state and RAM control
	always_comb begin
		state_d = state_q;
		we = 1'b0;
		addr = pos_q;
		wdata = ent_q;
		unique case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				if (op == OP_INSERT) begin
					if (cnt_q >= CW'(CAPACITY)) state_d = S_DONE;
					else if (cnt_q == '0) begin
						we = 1'b1; addr = '0; wdata = {key, tag}; state_d = S_DONE;
					end else begin
						addr = AW'((cnt_q - 1'b1) >> 2); state_d = S_UP_CMP;
					end
				end else begin
					if (cnt_q == '0) state_d = S_DONE;
					else begin addr = '0; state_d = S_EX_RD; end
				end
			end
			S_UP_RD: begin addr = par_q; state_d = S_UP_CMP; end
			S_UP_CMP: begin
				if (k_of(ent_q) < k_of(rdata)) begin
					we = 1'b1; addr = pos_q; wdata = rdata;
					// finish at the root through the final write state
					state_d = (par_q == '0) ? S_EX_ROOT : S_UP_RD;
				end else begin
					we = 1'b1; addr = pos_q; wdata = ent_q; state_d = S_DONE;
				end
			end
			S_EX_RD: begin addr = AW'(lim_q); state_d = S_EX_ROOT; end
			S_EX_ROOT: begin
				// final write of the moving entry, or extract: wait for last entry
				if (first_q == '1) begin
					we = 1'b1; addr = pos_q; wdata = ent_q; state_d = S_DONE;
				end else begin
					addr = AW'(lim_q); state_d = S_DN_RD;
				end
			end
			S_DN_RD: begin
				if (child_c < (CW+2)'(lim_q) && ci_q < 3'd4) begin
					addr = AW'(child_c); state_d = S_DN_CMP;
				end else begin
					we = 1'b1;
					if (have_best_q && k_of(best_q) < k_of(ent_q)) begin
						addr = pos_q; wdata = best_q;
						if (next_first < (CW+2)'(lim_q)) state_d = S_DN_RD;
						else begin state_d = S_EX_ROOT; end
					end else begin
						addr = pos_q; wdata = ent_q; state_d = S_DONE;
					end
				end
			end
			S_DN_CMP: state_d = S_DN_RD;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid <= 1'b0;
			out_key <= '0;
			out_tag <= '0;
			status <= ST_OK;
			count <= '0;
		end else begin
			if (state_q == S_DONE) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (state_q == S_IDLE && in_valid && in_ready) begin
				out_key <= '0; out_tag <= '0;
				if (op == OP_INSERT) begin
					if (cnt_q >= CW'(CAPACITY)) status <= ST_FULL;
					else begin status <= ST_OK; cnt_q <= cnt_q + 1'b1; end
				end else if (cnt_q == '0) status <= ST_EMPTY;
				else begin status <= ST_OK; cnt_q <= cnt_q - 1'b1; end
			end
			if (state_q == S_EX_RD) begin
				out_key <= 32'(k_of(rdata));
				out_tag <= 16'(rdata[TAG_BITS-1:0]);
			end
			if (state_q == S_DONE) count <= 9'(cnt_q);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ent_q <= {key, tag};
				pos_q <= AW'(cnt_q);
				par_q <= AW'((cnt_q - 1'b1) >> 2);
				lim_q <= cnt_q - 1'b1;
				first_q <= '0;
			end
			S_UP_CMP: if (k_of(ent_q) < k_of(rdata)) begin
				pos_q <= par_q;
				par_q <= AW'((par_q - 1'b1) >> 2);
				if (par_q == '0) first_q <= '1;
			end
			S_EX_ROOT: if (first_q != '1) begin
				ci_q <= '0; have_best_q <= 1'b0;
				first_q <= (CW+2)'(1); pos_q <= '0;
				if (state_d == S_DN_RD && first_q == '0) ent_q <= rdata;
			end
			S_DN_RD: begin
				if (!(child_c < (CW+2)'(lim_q) && ci_q < 3'd4)) begin
					pos_q <= best_pos_q;
					first_q <= (next_first < (CW+2)'(lim_q)) ? next_first : '1;
					ci_q <= '0; have_best_q <= 1'b0;
				end
			end
			S_DN_CMP: begin
				if (!have_best_q || k_of(rdata) < k_of(best_q)) begin
					best_q <= rdata; best_pos_q <= AW'(child_c);
				end
				have_best_q <= 1'b1;
				ci_q <= ci_q + 1'b1;
			end
			default: ;
		endcase
	end
endmodule
